FILE: sv/wwmv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the weighted window mean and variance block
// no dependencies

package wwmv_pkg;

  // default sizing of the sample ring
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 24;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int WLEN_W     = 7;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int MEAN_W     = 40;
  localparam int SQM_W      = 56;
  localparam int OUT_MEAN_W = 32;
  localparam int OUT_VAR_W  = 48;

  // Q1.16 unity and register reset values
  localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 7'd16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'h10000;
  localparam logic [WEIGHT_W-1:0] NORM_RESET   = 17'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_WEIGHT     = 2'd1,
    CFG_WEIGHT_POW = 2'd2,
    CFG_NORM_SCALE = 2'd3
  } cfg_index_t;

  // multiplier operations, each with fixed operands and destination
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_O_KN,
    MUL_O_O,
    MUL_X_X,
    MUL_MLO_K,
    MUL_MHI_K,
    MUL_OOLO_KN,
    MUL_OOHI_KN,
    MUL_D1LO_S,
    MUL_D1HI_S,
    MUL_M2LO_K,
    MUL_M2HI_K,
    MUL_D2LO_S,
    MUL_D2HI_S,
    MUL_MEAN_SQ
  } mul_op_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_AGED,
    ST_OSQ,
    ST_XSQ,
    ST_KM_LO,
    ST_KM_HI,
    ST_A2_LO,
    ST_A2_HI,
    ST_DS_LO,
    ST_DS_HI,
    ST_KM2_LO,
    ST_KM2_HI,
    ST_DS2_LO,
    ST_DS2_HI,
    ST_MSQ,
    ST_SQM,
    ST_OUT,
    ST_CLEAR,
    ST_CLR_SWEEP
  } state_t;

  typedef struct packed {
    logic    in_ready;
    logic    ld_o;
    logic    diff1;
    logic    diff2;
    logic    upd_mean;
    logic    upd_sqm;
    logic    out_load;
    logic    clr_stats;
    logic    sweep;
    mul_op_t mul_op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/wwmv_intf.sv
`timescale 1ns / 1ps
// channel interfaces: sample input, result output and configuration writes
// depends on wwmv_pkg

interface wwmv_sample_if;
  import wwmv_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample;
  modport source(output valid, output mode, output sample, input ready);
  modport sink(input valid, input mode, input sample, output ready);
endinterface

interface wwmv_result_if;
  import wwmv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_MEAN_W-1:0] mean;
  logic [OUT_VAR_W-1:0]  variance;
  modport source(output valid, output mean, output variance, input ready);
  modport sink(input valid, input mean, input variance, output ready);
endinterface

interface wwmv_cfg_if;
  import wwmv_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

FILE: sv/weighted_window_mean_variance.sv
`timescale 1ns / 1ps
// top level of the weighted window mean and variance block
// depends on wwmv_pkg, wwmv_intf, wwmv_ctrl, wwmv_datapath

// usage
// - samples: valid/ready channel, one transaction per timer period sample (mode 0)
//   or a clear command (mode 1, sample ignored)
// - results: valid/ready channel, one transaction (mean Q24.8, variance in ticks
//   squared) for every sample and every clear
// - cfg: write-only register channel, always ready; write only while the block is idle
// - all multiplies of a sample go through one shared 32x32 multiplier in a fixed
//   sequence of steps
// - a clear zeroes the statistics, then sweeps the ring with zeros, one slot a
//   cycle, and its zero result follows the sweep
// - one item is worked on at a time, so a new one is not taken until the last is done
// - after reset every ring slot is swept to zero before the first sample
//   is accepted; config registers take their reset values at once
// - a finished result sits in an output register; the next item is accepted
//   while it waits, and the sequencer holds in its last step until the receiver
//   has taken the previous result

module weighted_window_mean_variance #(
  parameter int MAX_WINDOW  = wwmv_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = wwmv_pkg::DEF_SAMPLE_BITS
) (
  input logic           clk,
  input logic           rst,
  wwmv_sample_if.sink   samples,
  wwmv_result_if.source results,
  wwmv_cfg_if.sink      cfg
);
  import wwmv_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // step sequencer
  wwmv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .cmd   (cmd)
  );

  // ring memory, multiplier, statistics and channel registers
  wwmv_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .samples(samples),
    .results(results),
    .cfg    (cfg)
  );

endmodule

FILE: sv/wwmv_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module wwmv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/wwmv_ctrl.sv
`timescale 1ns / 1ps
// sequencer for one sample update, clear handling and ring sweeps
// depends on wwmv_pkg

module wwmv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  wwmv_pkg::status_t status,
  output wwmv_pkg::cmd_t    cmd
);
  import wwmv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:      if (status.sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (status.in_valid) begin
          state_next = status.in_mode ? ST_CLEAR : ST_LOAD;
        end
      end
      ST_LOAD:      state_next = ST_AGED;
      ST_AGED:      state_next = ST_OSQ;
      ST_OSQ:       state_next = ST_XSQ;
      ST_XSQ:       state_next = ST_KM_LO;
      ST_KM_LO:     state_next = ST_KM_HI;
      ST_KM_HI:     state_next = ST_A2_LO;
      ST_A2_LO:     state_next = ST_A2_HI;
      ST_A2_HI:     state_next = ST_DS_LO;
      ST_DS_LO:     state_next = ST_DS_HI;
      ST_DS_HI:     state_next = ST_KM2_LO;
      ST_KM2_LO:    state_next = ST_KM2_HI;
      ST_KM2_HI:    state_next = ST_DS2_LO;
      ST_DS2_LO:    state_next = ST_DS2_HI;
      ST_DS2_HI:    state_next = ST_MSQ;
      ST_MSQ:       state_next = ST_SQM;
      ST_SQM:       state_next = ST_OUT;
      ST_OUT:       if (status.out_free) state_next = ST_IDLE;
      ST_CLEAR:     state_next = ST_CLR_SWEEP;
      ST_CLR_SWEEP: if (status.sweep_last) state_next = ST_OUT;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    unique case (state)
      ST_INIT:      cmd.sweep = 1'b1;
      ST_IDLE:      cmd.in_ready = 1'b1;
      ST_LOAD:      cmd.ld_o = 1'b1;
      ST_AGED:      cmd.mul_op = MUL_O_KN;
      ST_OSQ:       cmd.mul_op = MUL_O_O;
      ST_XSQ: begin
        cmd.mul_op = MUL_X_X;
        cmd.diff1  = 1'b1;
      end
      ST_KM_LO:     cmd.mul_op = MUL_MLO_K;
      ST_KM_HI:     cmd.mul_op = MUL_MHI_K;
      ST_A2_LO:     cmd.mul_op = MUL_OOLO_KN;
      ST_A2_HI:     cmd.mul_op = MUL_OOHI_KN;
      ST_DS_LO:     cmd.mul_op = MUL_D1LO_S;
      ST_DS_HI: begin
        cmd.mul_op = MUL_D1HI_S;
        cmd.diff2  = 1'b1;
      end
      ST_KM2_LO:    cmd.mul_op = MUL_M2LO_K;
      ST_KM2_HI: begin
        cmd.mul_op   = MUL_M2HI_K;
        cmd.upd_mean = 1'b1;
      end
      ST_DS2_LO:    cmd.mul_op = MUL_D2LO_S;
      ST_DS2_HI:    cmd.mul_op = MUL_D2HI_S;
      ST_MSQ:       cmd.mul_op = MUL_MEAN_SQ;
      ST_SQM:       cmd.upd_sqm = 1'b1;
      ST_OUT:       cmd.out_load = status.out_free;
      ST_CLEAR:     cmd.clr_stats = 1'b1;
      ST_CLR_SWEEP: cmd.sweep = 1'b1;
      default:      cmd.in_ready = 1'b0;
    endcase
  end

endmodule

FILE: sv/wwmv_datapath.sv
`timescale 1ns / 1ps
// sample ring, shared multiplier, statistics, config registers and result register
// depends on wwmv_pkg, wwmv_intf and wwmv_ram

module wwmv_datapath #(
  parameter int MAX_WINDOW  = wwmv_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = wwmv_pkg::DEF_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  wwmv_pkg::cmd_t    cmd,
  output wwmv_pkg::status_t status,
  wwmv_sample_if.sink       samples,
  wwmv_result_if.source     results,
  wwmv_cfg_if.sink          cfg
);
  import wwmv_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = (IDX_W + 1 > WLEN_W) ? IDX_W + 1 : WLEN_W;

  function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [CFG_DATA_W-1:0] v);
    return (v > CFG_DATA_W'(ONE_Q16)) ? ONE_Q16 : WEIGHT_W'(v);
  endfunction

  // configuration, weights held already clamped to one
  logic [WLEN_W-1:0]   window_len;
  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] weight_pow;
  logic [WEIGHT_W-1:0] norm_scale;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_RESET;
      weight     <= WEIGHT_RESET;
      weight_pow <= WEIGHT_RESET;
      norm_scale <= NORM_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WINDOW_LEN: window_len <= cfg.data[WLEN_W-1:0];
        CFG_WEIGHT:     weight     <= clamp_weight(cfg.data);
        CFG_WEIGHT_POW: weight_pow <= clamp_weight(cfg.data);
        CFG_NORM_SCALE: norm_scale <= clamp_weight(cfg.data);
        default:        window_len <= window_len;
      endcase
    end
  end

  // ring slot selection
  logic [LEN_W-1:0]    len_raw;
  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    slot_inc;
  logic [IDX_W-1:0]    oldest;
  logic [IDX_W-1:0]    slot_eff;
  logic [IDX_W-1:0]    slot;
  logic [IDX_W-1:0]    sweep_cnt;
  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] o;
  logic                accept;

  always_comb begin
    len_raw = LEN_W'(window_len);
    if (len_raw == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = len_raw;
    end
    slot_eff = (LEN_W'(oldest) >= eff_len) ? '0 : oldest;
    slot_inc = LEN_W'(slot) + LEN_W'(1);
  end

  assign samples.ready = cmd.in_ready;
  assign accept        = samples.valid & cmd.in_ready;

  // sample ring
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign ram_we    = cmd.ld_o | cmd.sweep;
  assign ram_waddr = cmd.sweep ? sweep_cnt : slot;
  assign ram_wdata = cmd.sweep ? '0 : x[SAMPLE_BITS-1:0];

  wwmv_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot_eff),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      x    <= SAMPLE_W'(samples.sample[SAMPLE_BITS-1:0]);
      slot <= slot_eff;
    end
    if (cmd.ld_o) begin
      o <= SAMPLE_W'(ram_rdata);
    end
  end

  assign status.sweep_last = (sweep_cnt == IDX_W'(MAX_WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.clr_stats) begin
        oldest    <= '0;
        sweep_cnt <= '0;
      end else if (cmd.sweep) begin
        sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + IDX_W'(1);
      end else if (cmd.ld_o) begin
        oldest <= (slot_inc >= eff_len) ? '0 : slot_inc[IDX_W-1:0];
      end
    end
  end

  // shared multiplier, one product a cycle, written back the cycle after
  logic [MEAN_W-1:0] mean;
  logic [SQM_W-1:0]  sqm;
  logic [39:0]       aged;
  logic [47:0]       oo;
  logic [47:0]       xx;
  logic [56:0]       km;
  logic [64:0]       a2;
  logic [56:0]       ds;
  logic [72:0]       km2;
  logic [72:0]       ds2;
  logic [63:0]       msq;
  logic [39:0]       d1;
  logic              neg1;
  logic [56:0]       d2;
  logic              neg2;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  mul_op_t           op_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_O_KN: begin
        mul_a = 32'(o);
        mul_b = 32'(weight_pow);
      end
      MUL_O_O: begin
        mul_a = 32'(o);
        mul_b = 32'(o);
      end
      MUL_X_X: begin
        mul_a = 32'(x);
        mul_b = 32'(x);
      end
      MUL_MLO_K: begin
        mul_a = mean[31:0];
        mul_b = 32'(weight);
      end
      MUL_MHI_K: begin
        mul_a = 32'(mean[39:32]);
        mul_b = 32'(weight);
      end
      MUL_OOLO_KN: begin
        mul_a = oo[31:0];
        mul_b = 32'(weight_pow);
      end
      MUL_OOHI_KN: begin
        mul_a = 32'(oo[47:32]);
        mul_b = 32'(weight_pow);
      end
      MUL_D1LO_S: begin
        mul_a = d1[31:0];
        mul_b = 32'(norm_scale);
      end
      MUL_D1HI_S: begin
        mul_a = 32'(d1[39:32]);
        mul_b = 32'(norm_scale);
      end
      MUL_M2LO_K: begin
        mul_a = sqm[31:0];
        mul_b = 32'(weight);
      end
      MUL_M2HI_K: begin
        mul_a = 32'(sqm[55:32]);
        mul_b = 32'(weight);
      end
      MUL_D2LO_S: begin
        mul_a = d2[31:0];
        mul_b = 32'(norm_scale);
      end
      MUL_D2HI_S: begin
        mul_a = 32'(d2[56:32]);
        mul_b = 32'(norm_scale);
      end
      MUL_MEAN_SQ: begin
        mul_a = mean[39:8];
        mul_b = mean[39:8];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      op_q <= MUL_NONE;
    end else begin
      op_q <= cmd.mul_op;
    end
  end

  // write back, high halves added in on top of the low half
  always_ff @(posedge clk) begin
    case (op_q)
      MUL_O_KN:    aged <= prod[39:0];
      MUL_O_O:     oo   <= prod[47:0];
      MUL_X_X:     xx   <= prod[47:0];
      MUL_MLO_K:   km   <= 57'(prod);
      MUL_MHI_K:   km   <= km + (57'(prod) << 32);
      MUL_OOLO_KN: a2   <= 65'(prod);
      MUL_OOHI_KN: a2   <= a2 + (65'(prod) << 32);
      MUL_D1LO_S:  ds   <= 57'(prod);
      MUL_D1HI_S:  ds   <= ds + (57'(prod) << 32);
      MUL_M2LO_K:  km2  <= 73'(prod);
      MUL_M2HI_K:  km2  <= km2 + (73'(prod) << 32);
      MUL_D2LO_S:  ds2  <= 73'(prod);
      MUL_D2HI_S:  ds2  <= ds2 + (73'(prod) << 32);
      MUL_MEAN_SQ: msq  <= prod;
      default:     ;
    endcase
    if (cmd.clr_stats) begin
      msq <= '0;
    end
  end

  // sign and magnitude of the fresh minus aged terms
  logic [39:0] fresh1;
  logic [56:0] fresh2;
  logic [56:0] aged2;

  assign fresh1 = {x, 16'b0};
  assign fresh2 = {1'b0, xx, 8'b0};
  assign aged2  = a2[64:8];

  always_ff @(posedge clk) begin
    if (cmd.diff1) begin
      if (fresh1 >= aged) begin
        d1   <= fresh1 - aged;
        neg1 <= 1'b0;
      end else begin
        d1   <= aged - fresh1;
        neg1 <= 1'b1;
      end
    end
    if (cmd.diff2) begin
      if (fresh2 >= aged2) begin
        d2   <= fresh2 - aged2;
        neg2 <= 1'b0;
      end else begin
        d2   <= aged2 - fresh2;
        neg2 <= 1'b1;
      end
    end
  end

  // blend and saturate
  logic signed [42:0] mean_acc;
  logic signed [58:0] sqm_acc;
  logic [MEAN_W-1:0]  mean_sat;
  logic [SQM_W-1:0]   sqm_sat;

  always_comb begin
    if (neg1) begin
      mean_acc = signed'({2'b0, km[56:16]}) - signed'({2'b0, ds[56:16]});
    end else begin
      mean_acc = signed'({2'b0, km[56:16]}) + signed'({2'b0, ds[56:16]});
    end
    if (mean_acc < 0) begin
      mean_sat = '0;
    end else if (mean_acc > signed'(43'({MEAN_W{1'b1}}))) begin
      mean_sat = '1;
    end else begin
      mean_sat = mean_acc[MEAN_W-1:0];
    end

    if (neg2) begin
      sqm_acc = signed'({2'b0, km2[72:16]}) - signed'({2'b0, ds2[72:16]});
    end else begin
      sqm_acc = signed'({2'b0, km2[72:16]}) + signed'({2'b0, ds2[72:16]});
    end
    if (sqm_acc < 0) begin
      sqm_sat = '0;
    end else if (sqm_acc > signed'(59'({SQM_W{1'b1}}))) begin
      sqm_sat = '1;
    end else begin
      sqm_sat = sqm_acc[SQM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
      sqm  <= '0;
    end else if (cmd.clr_stats) begin
      mean <= '0;
      sqm  <= '0;
    end else begin
      if (cmd.upd_mean) mean <= mean_sat;
      if (cmd.upd_sqm)  sqm  <= sqm_sat;
    end
  end

  // variance and result register
  logic [63:0]           m2_16;
  logic [63:0]           var_diff;
  logic [OUT_VAR_W-1:0]  var_val;
  logic                  out_valid;
  logic [OUT_MEAN_W-1:0] out_mean;
  logic [OUT_VAR_W-1:0]  out_var;

  assign m2_16    = {sqm, 8'b0};
  assign var_diff = m2_16 - msq;
  assign var_val  = (m2_16 > msq) ? var_diff[63:16] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_mean <= mean[39:8];
      out_var  <= var_val;
    end
  end

  assign results.valid    = out_valid;
  assign results.mean     = out_mean;
  assign results.variance = out_var;

  assign status.out_free = ~out_valid | results.ready;
  assign status.in_valid = samples.valid;
  assign status.in_mode  = samples.mode;

endmodule

FILE: sim/wwmv_stats_checker.sv
`timescale 1ns / 1ps
// scoreboard for the weighted window mean and variance block: watches the sample, result
// and register channels, predicts each result transaction and compares it field by field
// depends on wwmv_pkg and wwmv_intf

module wwmv_stats_checker
  import wwmv_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  wwmv_sample_if      samples,
  wwmv_result_if      results,
  wwmv_cfg_if         cfg,
  input  logic        drain_done,
  output int unsigned outstanding,
  output int unsigned checked,
  output int unsigned failures
);

  typedef struct packed {
    logic [OUT_MEAN_W-1:0] mean;
    logic [OUT_VAR_W-1:0]  variance;
  } window_stats_t;

  localparam logic [63:0] MEAN_TOP    = (64'd1 << MEAN_W) - 1;
  localparam logic [63:0] SQM_TOP     = (64'd1 << SQM_W) - 1;
  localparam logic [63:0] SAMPLE_KEEP = (64'd1 << SAMPLE_BITS) - 1;

  // predicted state of the block
  logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
  int unsigned         oldest;
  logic [MEAN_W-1:0]   mean_acc;
  logic [SQM_W-1:0]    sqm_acc;
  logic [WLEN_W-1:0]   wlen_reg;
  logic [WEIGHT_W-1:0] k_reg;
  logic [WEIGHT_W-1:0] kn_reg;
  logic [WEIGHT_W-1:0] s_reg;

  window_stats_t       pending_stats[$];
  int unsigned         n_checked;
  int unsigned         fail_total;
  bit                  leftovers_done;

  function automatic logic [WEIGHT_W-1:0] unity_cap(input logic [WEIGHT_W-1:0] w);
    return (w > ONE_Q16) ? ONE_Q16 : w;
  endfunction

  // (a * w) >> 16, a below 2^56
  function automatic logic [63:0] scale_q16(input logic [63:0] a,
                                            input logic [WEIGHT_W-1:0] w);
    logic [80:0] prod;
    prod = a * w;
    return prod[79:16];
  endfunction

  // k*old + (fresh - aged)*s, the difference scaled by magnitude, result held in [0, top]
  function automatic logic [63:0] blend_step(input logic [63:0] old, fresh, aged,
                                             input logic [WEIGHT_W-1:0] k, s,
                                             input logic [63:0] top);
    logic signed [67:0] acc;
    acc = $signed({4'b0, scale_q16(old, k)});
    if (fresh >= aged) acc = acc + $signed({4'b0, scale_q16(fresh - aged, s)});
    else acc = acc - $signed({4'b0, scale_q16(aged - fresh, s)});
    if (acc < 0) acc = '0;
    else if (acc > $signed({4'b0, top})) acc = $signed({4'b0, top});
    return acc[63:0];
  endfunction

  function automatic window_stats_t advance_window(input logic clear,
                                                   input logic [SAMPLE_W-1:0] raw);
    window_stats_t       r;
    int unsigned         len;
    logic [WEIGHT_W-1:0] k, kn, s;
    logic [63:0]         x64, o64, mean8, m2_16, msq, var_full;
    if (clear) begin
      foreach (ring[i]) ring[i] = '0;
      oldest   = 0;
      mean_acc = '0;
      sqm_acc  = '0;
      r.mean     = '0;
      r.variance = '0;
      return r;
    end
    len = 32'(wlen_reg);
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    if (oldest >= len) oldest = 0;
    k  = unity_cap(k_reg);
    kn = unity_cap(kn_reg);
    s  = unity_cap(s_reg);
    x64 = 64'(raw) & SAMPLE_KEEP;
    o64 = 64'(ring[oldest]);
    mean_acc = MEAN_W'(blend_step(64'(mean_acc), x64 << 16, scale_q16(o64 << 16, kn),
                                  k, s, MEAN_TOP));
    sqm_acc  = SQM_W'(blend_step(64'(sqm_acc), (x64 * x64) << 8, (o64 * o64 * kn) >> 8,
                                 k, s, SQM_TOP));
    ring[oldest] = x64[SAMPLE_W-1:0];
    oldest = oldest + 1;
    if (oldest >= len) oldest = 0;
    mean8    = 64'(mean_acc) >> 8;
    m2_16    = {sqm_acc, 8'b0};
    msq      = mean8 * mean8;
    var_full = (m2_16 > msq) ? (m2_16 - msq) >> 16 : 64'd0;
    r.mean     = mean8[OUT_MEAN_W-1:0];
    r.variance = var_full[OUT_VAR_W-1:0];
    return r;
  endfunction

  task automatic log_failure(input string what);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    window_stats_t got;
    window_stats_t want;
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      oldest   = 0;
      mean_acc = '0;
      sqm_acc  = '0;
      wlen_reg = WLEN_RESET;
      k_reg    = WEIGHT_RESET;
      kn_reg   = WEIGHT_RESET;
      s_reg    = NORM_RESET;
      pending_stats.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WINDOW_LEN: wlen_reg = cfg.data[WLEN_W-1:0];
          CFG_WEIGHT:     k_reg    = cfg.data;
          CFG_WEIGHT_POW: kn_reg   = cfg.data;
          CFG_NORM_SCALE: s_reg    = cfg.data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        pending_stats.push_back(advance_window(samples.mode, samples.sample));
      if (results.valid && results.ready) begin
        got.mean     = results.mean;
        got.variance = results.variance;
        n_checked++;
        if (pending_stats.size() == 0) begin
          log_failure($sformatf("unexpected result: mean %h variance %h",
                                got.mean, got.variance));
        end else begin
          want = pending_stats.pop_front();
          if (got.mean !== want.mean || got.variance !== want.variance)
            log_failure($sformatf(
              "result %0d: mean exp %h got %h, variance exp %h got %h",
              n_checked, want.mean, got.mean, want.variance, got.variance));
        end
      end
      if (drain_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_stats.size() != 0)
          log_failure($sformatf("%0d results never arrived", pending_stats.size()));
      end
    end
    outstanding <= pending_stats.size();
    checked     <= n_checked;
    failures    <= fail_total;
  end

endmodule

FILE: sim/weighted_window_mean_variance_tb.sv
`timescale 1ns / 1ps
// testbench top for weighted_window_mean_variance: clock, reset, stimulus and verdict
// depends on wwmv_pkg, wwmv_intf, wwmv_stats_checker and the block under test

module weighted_window_mean_variance_tb;
  import wwmv_pkg::*;

  // worst item time (sender gap, clear sweep, receiver stall), times
  // some 450 items, plus the long hold and the pauses between settings; taken several times
  localparam int CYCLE_LIMIT   = 400_000;
  // longer than a clear sweep of the full ring, so this covers anything still in flight
  localparam int SETTLE_CYCLES = 80;
  // long receiver hold-off, well beyond one item time so the input backs up
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 62;

  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;

  // receiver behaviour, switched to a new random style after a random stretch
  typedef enum bit [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_RUNS
  } rx_style_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        drain_done;
  bit          hold_go;
  bit          steady;
  int unsigned burst_left;
  int unsigned pending, checked, failures;
  int unsigned cycle_count;
  int unsigned sent, clears_sent, cfg_writes;

  wwmv_sample_if sample_ch();
  wwmv_result_if result_ch();
  wwmv_cfg_if    cfg_ch();

  weighted_window_mean_variance i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  wwmv_stats_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .samples     (sample_ch),
    .results     (result_ch),
    .cfg         (cfg_ch),
    .drain_done  (drain_done),
    .outstanding (pending),
    .checked     (checked),
    .failures    (failures)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("no completion within %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result receiver: its own stall pattern, plus one long hold-off on request
  initial begin : receiver
    rx_style_t   style;
    int unsigned style_left, hold_left, tick, run_left;
    bit          hold_taken, level;
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(50, 300);
        end
        style_left--;
        tick++;
        case (style)
          RX_OPEN:         result_ch.ready <= 1'b1;
          RX_COIN:         result_ch.ready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: result_ch.ready <= (tick % 4 == 0);
          default: begin
            // alternating runs: short open windows, longer stalls
            if (run_left == 0) begin
              level    = !level;
              run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 40);
            end
            run_left--;
            result_ch.ready <= level;
          end
        endcase
      end
    end
  end

  // one sample or clear transaction; bursts of random length, idle gaps in between
  task automatic offer(input logic clear_req, input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        // idle payload is noise, the block must ignore it
        sample_ch.valid  <= 1'b0;
        sample_ch.mode   <= 1'($urandom_range(0, 1));
        sample_ch.sample <= SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    sample_ch.valid  <= 1'b1;
    sample_ch.mode   <= clear_req;
    sample_ch.sample <= value;
    do @(posedge clk); while (!sample_ch.ready);
    sent++;
    if (clear_req) clears_sent++;
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic go_quiet();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  // valid stays high across consecutive writes; the caller lowers it once
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_writes++;
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] len, k, kn, s);
    go_quiet();
    write_reg(CFG_WINDOW_LEN, len);
    write_reg(CFG_WEIGHT, k);
    write_reg(CFG_WEIGHT_POW, kn);
    write_reg(CFG_NORM_SCALE, s);
    cfg_ch.valid <= 1'b0;
  endtask

  // what software would program for a given window and weight: K^N and the
  // normalisation (1-K)/(1-K^N), or 1/N for unit weight
  function automatic void tuned_weights(input int unsigned len,
                                        input logic [WEIGHT_W-1:0] k,
                                        output logic [WEIGHT_W-1:0] kn,
                                        output logic [WEIGHT_W-1:0] s);
    logic [63:0] acc, num, den, q;
    acc = 64'd65536;
    repeat (len) acc = (acc * k) >> 16;
    kn = acc[WEIGHT_W-1:0];
    if (k >= ONE_Q16) begin
      q = 64'd65536 / len;
    end else begin
      num = (64'd65536 - k) << 16;
      den = 64'd65536 - acc;
      q   = num / den;
      if (q > ONE_Q16) q = ONE_Q16;
    end
    s = q[WEIGHT_W-1:0];
  endfunction

  // mostly jittered periods around a nominal value, some wild samples and clears
  task automatic random_phase(input int unsigned n_items);
    int unsigned base, spread, pick;
    int          val;
    base   = $urandom_range(0, SAMPLE_TOP);
    spread = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        offer(1'b1, SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
      end else if (pick < 13) begin
        offer(1'b0, SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
      end else if (pick < 16) begin
        offer(1'b0, $urandom_range(0, 1) ? SAMPLE_TOP : '0);
      end else begin
        val = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (val < 0) val = 0;
        if (val > int'(SAMPLE_TOP)) val = int'(SAMPLE_TOP);
        offer(1'b0, val[SAMPLE_W-1:0]);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned         len;
    logic [WEIGHT_W-1:0] k, kn, s;
    rst              <= 1'b1;
    drain_done       <= 1'b0;
    hold_go          <= 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.mode   <= 1'b0;
    sample_ch.sample <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_WINDOW_LEN;
    cfg_ch.data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: plain 16-sample average; extremes, a falling step, bit patterns,
    // and a clear whose sample field is full scale
    offer(1'b0, '0);
    offer(1'b0, SAMPLE_TOP);
    offer(1'b0, SAMPLE_TOP);
    offer(1'b0, '0);
    offer(1'b0, 24'hAAAAAA);
    offer(1'b0, 24'h555555);
    offer(1'b1, SAMPLE_TOP);
    offer(1'b0, SAMPLE_TOP);

    // weights above unity act as one, window length 127 acts as the full ring;
    // full scale samples drive both statistics into saturation
    load_settings('1, '1, '1, '1);
    offer(1'b0, SAMPLE_TOP);
    offer(1'b0, SAMPLE_TOP);
    offer(1'b0, SAMPLE_TOP);
    offer(1'b0, '0);

    // zero length acts as one, so the oldest slot wraps; zero weight means mean = sample
    load_settings('0, '0, '0, ONE_Q16);
    offer(1'b0, 24'h123456);
    offer(1'b0, 24'h800000);

    // zero normalisation: new samples have no effect, the statistics decay
    load_settings(17'd64, 17'h08000, 17'h00100, '0);
    repeat (3) offer(1'b0, SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));

    // random settings, each followed by a run of mostly well-formed period samples
    for (int p = 0; p < 7; p++) begin
      if (p == 0) begin
        len = 64;
        k   = ONE_Q16;
      end else if (p == 1) begin
        len = 1;
        k   = WEIGHT_W'($urandom_range(32768, 65535));
      end else begin
        len = $urandom_range(1, 64);
        k   = $urandom_range(0, 1) ? ONE_Q16 : WEIGHT_W'($urandom_range(32768, 65535));
      end
      tuned_weights(len, k, kn, s);
      if (p >= 2 && $urandom_range(0, 3) == 0)
        load_settings(CFG_DATA_W'($urandom_range(0, 17'h1FFFF)),
                      CFG_DATA_W'($urandom_range(0, 17'h1FFFF)),
                      CFG_DATA_W'($urandom_range(0, 17'h1FFFF)),
                      CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
      else
        load_settings(CFG_DATA_W'(len), k, kn, s);
      // one long receiver hold-off while the sender keeps offering, so the input stalls
      if (p == 2) hold_go <= 1'b1;
      // back-to-back items with no sender gaps in one phase
      steady = (p == 4);
      random_phase(PHASE_ITEMS);
    end

    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("%0d input transactions (%0d clears), %0d register writes, %0d results compared",
             sent, clears_sent, cfg_writes, checked);
    $display("window lengths 0 to 127, weights from zero to above unity, one long output hold");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", failures);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: weighted_window_mean_variance.f
sv/wwmv_pkg.sv
sv/wwmv_intf.sv
sv/wwmv_ram.sv
sv/wwmv_ctrl.sv
sv/wwmv_datapath.sv
sv/weighted_window_mean_variance.sv
sim/wwmv_stats_checker.sv
sim/weighted_window_mean_variance_tb.sv
